[hdl/rtsf_pkg.sv]
package rtsf_pkg;

   localparam int unsigned SUM_BITS = 32;
   localparam int unsigned SQ_BITS = 46;
   localparam int unsigned ERR_BITS = 62;
   localparam int unsigned VAL_BITS = 16;
   localparam int unsigned FEAT_BITS = 6;
   localparam int unsigned NODE_BITS = 6;
   localparam int unsigned PROD_BITS = 64;

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_BEGIN  = 2'd1,
      OP_SAMPLE = 2'd2,
      OP_REPORT = 2'd3
   } op_type;

   localparam logic [0:0] CSR_LEAF_MIN = 1'd0;
   localparam logic [0:0] CSR_ERROR_LIMIT = 1'd1;

   localparam logic [ERR_BITS-1:0] ERROR_LIMIT_RESET = 62'd100000;

   typedef struct packed {
      logic load;
      logic sample;
      logic report;
      logic mul_l;
      logic mul_r;
      logic div_start;
      logic div_sel_r;
      logic take_a;
      logic take_b;
      logic finish;
   } ctl_type;

   typedef struct packed {
      logic div_done;
      logic can_score;
      logic skip;
   } sts_type;

endpackage

[hdl/regression_tree_split_finder.sv]
// Load and begin-feature are done at the accepting edge; a report passes S_READ and S_CHECK,
// raises rsp_valid from a register for an in-range node, and frees the input.
// A sample passes S_READ and S_CHECK and may end there or go on to S_JOIN; when a split is
// scored it first runs two 64-step divisions on the shared radix-2 divider.
// Throughput: one request at a time while busy is high; results last one cycle, no stall.
// Reset: synchronous, clears control state, node flags and the CSR registers to their defaults.
module regression_tree_split_finder #(
   parameter int unsigned NODES = 64,
   parameter int unsigned FEATURES = 64,
   parameter int unsigned COUNT_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [1:0]           req_opcode,
   input  logic [5:0]           req_node,
   input  logic [5:0]           req_feature,
   input  logic signed [15:0]   req_value,
   input  logic signed [15:0]   req_target,
   input  logic [15:0]          req_total_count,
   input  logic signed [31:0]   req_total_sum,
   input  logic [45:0]          req_total_sqsum,
   input  logic                 csr_write_enable,
   input  logic [0:0]           csr_index,
   input  logic [61:0]          csr_write_data,
   output logic                 rsp_valid,
   output logic [5:0]           rsp_out_node,
   output logic                 rsp_found,
   output logic [5:0]           rsp_best_feature_out,
   output logic signed [15:0]   rsp_threshold,
   output logic [15:0]          rsp_left_count_out,
   output logic [15:0]          rsp_right_count_out,
   output logic signed [31:0]   rsp_left_sum_out,
   output logic signed [31:0]   rsp_right_sum_out,
   output logic [45:0]          rsp_left_sqsum_out,
   output logic [45:0]          rsp_right_sqsum_out,
   output logic [61:0]          rsp_split_error
);

   rtsf_pkg::ctl_type ctl;
   rtsf_pkg::sts_type sts;
   logic              accept;

   rtsf_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_opcode (req_opcode),
      .sts        (sts),
      .busy       (busy),
      .accept     (accept),
      .ctl        (ctl)
   );

   rtsf_datapath #(
      .NODES      (NODES),
      .FEATURES   (FEATURES),
      .COUNT_BITS (COUNT_BITS)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .ctl                  (ctl),
      .sts                  (sts),
      .accept               (accept),
      .req_opcode           (req_opcode),
      .req_node             (req_node),
      .req_feature          (req_feature),
      .req_value            (req_value),
      .req_target           (req_target),
      .req_total_count      (req_total_count),
      .req_total_sum        (req_total_sum),
      .req_total_sqsum      (req_total_sqsum),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .rsp_valid            (rsp_valid),
      .rsp_out_node         (rsp_out_node),
      .rsp_found            (rsp_found),
      .rsp_best_feature_out (rsp_best_feature_out),
      .rsp_threshold        (rsp_threshold),
      .rsp_left_count_out   (rsp_left_count_out),
      .rsp_right_count_out  (rsp_right_count_out),
      .rsp_left_sum_out     (rsp_left_sum_out),
      .rsp_right_sum_out    (rsp_right_sum_out),
      .rsp_left_sqsum_out   (rsp_left_sqsum_out),
      .rsp_right_sqsum_out  (rsp_right_sqsum_out),
      .rsp_split_error      (rsp_split_error)
   );

   a_no_result_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy)) else $error("result without a request in flight");

   a_accept_sets_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && (rtsf_pkg::op_type'(req_opcode) == rtsf_pkg::OP_SAMPLE
         || rtsf_pkg::op_type'(req_opcode) == rtsf_pkg::OP_REPORT)) |=> busy)
      else $error("sample or report did not raise busy");

   a_single_div: assert property (@(posedge clock) disable iff (reset)
      !(ctl.mul_l && ctl.mul_r)) else $error("two multiplies in one cycle");

endmodule

[hdl/rtsf_divider.sv]
module rtsf_divider #(
   parameter int unsigned DEN_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [rtsf_pkg::PROD_BITS-1:0]       dividend,
   input  logic [DEN_BITS-1:0]                  divisor,
   output logic                                 done,
   output logic [rtsf_pkg::PROD_BITS-1:0]       quotient
);

   localparam int unsigned CNT_W = $clog2(rtsf_pkg::PROD_BITS + 1);

   logic [rtsf_pkg::PROD_BITS-1:0] quot_ff, quot_in;
   logic [DEN_BITS:0]              rem_ff, rem_in;
   logic [DEN_BITS-1:0]            den_ff;
   logic [CNT_W-1:0]               cnt_ff, cnt_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [DEN_BITS:0]              trial;

   always_comb begin
      quot_in = quot_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {rem_ff[DEN_BITS-1:0], quot_ff[rtsf_pkg::PROD_BITS-1]};
      if (start) begin
         quot_in = dividend;
         rem_in = '0;
         cnt_in = CNT_W'(rtsf_pkg::PROD_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quot_in = {quot_ff[rtsf_pkg::PROD_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quot_in = {quot_ff[rtsf_pkg::PROD_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff <= rem_in;
      if (start) begin
         den_ff <= divisor;
      end
   end

   assign done = done_ff;
   assign quotient = quot_ff;

endmodule

[hdl/rtsf_datapath.sv]
module rtsf_datapath #(
   parameter int unsigned NODES = 64,
   parameter int unsigned FEATURES = 64,
   parameter int unsigned COUNT_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  rtsf_pkg::ctl_type                    ctl,
   output rtsf_pkg::sts_type                    sts,
   input  logic                                 accept,
   input  logic [1:0]                           req_opcode,
   input  logic [5:0]                           req_node,
   input  logic [5:0]                           req_feature,
   input  logic signed [15:0]                   req_value,
   input  logic signed [15:0]                   req_target,
   input  logic [15:0]                          req_total_count,
   input  logic signed [31:0]                   req_total_sum,
   input  logic [45:0]                          req_total_sqsum,
   input  logic                                 csr_write_enable,
   input  logic [0:0]                           csr_index,
   input  logic [61:0]                          csr_write_data,
   output logic                                 rsp_valid,
   output logic [5:0]                           rsp_out_node,
   output logic                                 rsp_found,
   output logic [5:0]                           rsp_best_feature_out,
   output logic signed [15:0]                   rsp_threshold,
   output logic [15:0]                          rsp_left_count_out,
   output logic [15:0]                          rsp_right_count_out,
   output logic signed [31:0]                   rsp_left_sum_out,
   output logic signed [31:0]                   rsp_right_sum_out,
   output logic [45:0]                          rsp_left_sqsum_out,
   output logic [45:0]                          rsp_right_sqsum_out,
   output logic [61:0]                          rsp_split_error
);

   localparam int unsigned NIDX = (NODES > 1) ? $clog2(NODES) : 1;
   localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
   localparam int unsigned SB = rtsf_pkg::SUM_BITS;
   localparam int unsigned QB = rtsf_pkg::SQ_BITS;
   localparam int unsigned EB = rtsf_pkg::ERR_BITS;
   localparam int unsigned PB = rtsf_pkg::PROD_BITS;

   logic [COUNT_BITS-1:0] ncnt_mem [NODES];
   logic signed [SB-1:0]  nsum_mem [NODES];
   logic [QB-1:0]         nsq_mem [NODES];
   logic [COUNT_BITS-1:0] lcnt_mem [NODES];
   logic signed [SB-1:0]  lsum_mem [NODES];
   logic [QB-1:0]         lsq_mem [NODES];
   logic signed [15:0]    lval_mem [NODES];
   logic [EB-1:0]         berr_mem [NODES];
   logic [5:0]            bfeat_mem [NODES];
   logic signed [15:0]    bthr_mem [NODES];
   logic [COUNT_BITS-1:0] blcnt_mem [NODES];
   logic signed [SB-1:0]  blsum_mem [NODES];
   logic [QB-1:0]         blsq_mem [NODES];

   logic [NODES-1:0] active_ff;
   logic [NODES-1:0] lvalid_ff;
   logic [NODES-1:0] bvalid_ff;
   logic [NODES-1:0] found_ff;

   logic [15:0]    minc_ff;
   logic [EB-1:0]  elimit_ff;
   logic [5:0]     curfeat_ff;

   logic [NIDX-1:0]       n_ff;
   logic signed [15:0]    v_ff;
   logic signed [15:0]    t_ff;
   logic                  inrange_ff;
   logic [COUNT_BITS-1:0] nc_ff;
   logic signed [SB-1:0]  ns_ff;
   logic [QB-1:0]         nq_ff;
   logic [COUNT_BITS-1:0] l_ff;
   logic signed [SB-1:0]  ls_ff;
   logic [QB-1:0]         lq_ff;
   logic signed [15:0]    lv_ff;
   logic [EB-1:0]         be_ff;
   logic                  act_ff;
   logic                  fnd_ff;
   logic [5:0]            bf_ff;
   logic signed [15:0]    bt_ff;
   logic [COUNT_BITS-1:0] blc_ff;
   logic signed [SB-1:0]  bls_ff;
   logic [QB-1:0]         blq_ff;
   logic [31:0]           lm_ff;
   logic [SB:0]           rm_ff;
   logic [PB-1:0]         prod_ff;
   logic [PB-1:0]         a_ff;
   logic [EB-1:0]         err_ff;

   logic [NIDX-1:0]       n_idx;
   logic                  n_ok;
   logic [COUNT_BITS-1:0] r_cnt;
   logic [15:0]           mc;
   logic signed [SB:0]    rs;
   logic [PB-1:0]         quot;
   logic                  div_done;
   logic [PB:0]           e1, e2;
   logic                  rsp_valid_ff;

   assign n_idx = req_node[NIDX-1:0];
   assign n_ok = (32'(req_node) < NODES);
   assign r_cnt = nc_ff - l_ff;
   assign mc = (minc_ff == '0) ? 16'd1 : minc_ff;
   assign rs = {ns_ff[SB-1], ns_ff} - {ls_ff[SB-1], ls_ff};

   rtsf_divider #(.DEN_BITS(COUNT_BITS)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (ctl.div_start),
      .dividend (prod_ff),
      .divisor  (ctl.div_sel_r ? r_cnt : l_ff),
      .done     (div_done),
      .quotient (quot)
   );

   assign sts.div_done = div_done;
   assign sts.skip = !inrange_ff || !act_ff || (l_ff == CNT_MAX);
   assign sts.can_score = (l_ff != '0) && (v_ff != lv_ff) && ({16'd0, l_ff} >= 32'(mc))
      && (nc_ff >= l_ff) && ({16'd0, r_cnt} >= 32'(mc));

   always_ff @(posedge clock) begin
      if (reset) begin
         minc_ff <= 16'd1;
         elimit_ff <= rtsf_pkg::ERROR_LIMIT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            rtsf_pkg::CSR_LEAF_MIN: minc_ff <= csr_write_data[15:0];
            rtsf_pkg::CSR_ERROR_LIMIT: elimit_ff <= csr_write_data;
            default: minc_ff <= minc_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
         lvalid_ff <= '0;
         bvalid_ff <= '0;
         found_ff <= '0;
         curfeat_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctl.report && inrange_ff;
         if (accept && rtsf_pkg::op_type'(req_opcode) == rtsf_pkg::OP_BEGIN
               && 32'(req_feature) < FEATURES) begin
            curfeat_ff <= req_feature;
            lvalid_ff <= '0;
         end
         if (accept && rtsf_pkg::op_type'(req_opcode) == rtsf_pkg::OP_LOAD && n_ok) begin
            active_ff[n_idx] <= 1'b1;
            bvalid_ff[n_idx] <= 1'b1;
            found_ff[n_idx] <= 1'b0;
         end
         if (ctl.finish) begin
            lvalid_ff[n_ff] <= 1'b1;
         end
         if (ctl.take_b && err_ff < be_ff) begin
            bvalid_ff[n_ff] <= 1'b1;
            found_ff[n_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         n_ff <= n_idx;
         inrange_ff <= n_ok;
         v_ff <= req_value;
         t_ff <= req_target;
         if (rtsf_pkg::op_type'(req_opcode) == rtsf_pkg::OP_LOAD && n_ok) begin
            ncnt_mem[n_idx] <= req_total_count[COUNT_BITS-1:0];
            nsum_mem[n_idx] <= req_total_sum;
            nsq_mem[n_idx] <= req_total_sqsum;
            berr_mem[n_idx] <= elimit_ff;
         end
      end
      if (ctl.load) begin
         nc_ff <= ncnt_mem[n_ff];
         ns_ff <= nsum_mem[n_ff];
         nq_ff <= nsq_mem[n_ff];
         act_ff <= active_ff[n_ff];
         fnd_ff <= found_ff[n_ff];
         if (lvalid_ff[n_ff]) begin
            l_ff <= lcnt_mem[n_ff];
            ls_ff <= lsum_mem[n_ff];
            lq_ff <= lsq_mem[n_ff];
            lv_ff <= lval_mem[n_ff];
         end else begin
            l_ff <= '0;
            ls_ff <= '0;
            lq_ff <= '0;
            lv_ff <= '0;
         end
         if (bvalid_ff[n_ff]) begin
            be_ff <= berr_mem[n_ff];
         end else begin
            be_ff <= rtsf_pkg::ERROR_LIMIT_RESET;
         end
         if (found_ff[n_ff]) begin
            bf_ff <= bfeat_mem[n_ff];
            bt_ff <= bthr_mem[n_ff];
            blc_ff <= blcnt_mem[n_ff];
            bls_ff <= blsum_mem[n_ff];
            blq_ff <= blsq_mem[n_ff];
         end else begin
            bf_ff <= '0;
            bt_ff <= '0;
            blc_ff <= '0;
            bls_ff <= '0;
            blq_ff <= '0;
         end
      end
      if (ctl.sample) begin
         lm_ff <= ls_ff[SB-1] ? 32'(-ls_ff) : 32'(ls_ff);
         rm_ff <= rs[SB] ? (SB+1)'(-rs) : (SB+1)'(rs);
      end
      if (ctl.mul_l) begin
         prod_ff <= 64'(lm_ff) * 64'(lm_ff);
      end else if (ctl.mul_r) begin
         prod_ff <= 64'(rm_ff) * 64'(rm_ff);
      end
      if (ctl.take_a) begin
         a_ff <= quot;
      end
      if (ctl.take_b) begin
         if (err_ff < be_ff) begin
            berr_mem[n_ff] <= err_ff;
            bfeat_mem[n_ff] <= curfeat_ff;
            bthr_mem[n_ff] <= lv_ff;
            blcnt_mem[n_ff] <= l_ff;
            blsum_mem[n_ff] <= ls_ff;
            blsq_mem[n_ff] <= lq_ff;
         end
      end
      if (ctl.finish) begin
         lcnt_mem[n_ff] <= l_ff + 1'b1;
         lsum_mem[n_ff] <= ls_ff + SB'(t_ff);
         lsq_mem[n_ff] <= lq_ff + QB'(unsigned'(32'(t_ff) * 32'(t_ff)));
         lval_mem[n_ff] <= v_ff;
      end
   end

   always_comb begin
      e1 = {19'd0, nq_ff} - {1'b0, a_ff};
      if (e1[PB]) begin
         e1 = '0;
      end
      e2 = e1 - {1'b0, quot};
      if (e2[PB]) begin
         e2 = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.div_start || ctl.take_a) begin
         err_ff <= err_ff;
      end
      if (div_done && ctl.div_sel_r) begin
         err_ff <= e2[EB-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.report) begin
         rsp_out_node <= 6'(n_ff);
         rsp_found <= fnd_ff;
         rsp_split_error <= be_ff;
         if (fnd_ff) begin
            rsp_best_feature_out <= bf_ff;
            rsp_threshold <= bt_ff;
            rsp_left_count_out <= 16'(blc_ff);
            rsp_right_count_out <= (nc_ff >= blc_ff) ? 16'(nc_ff - blc_ff) : 16'd0;
            rsp_left_sum_out <= bls_ff;
            rsp_right_sum_out <= ns_ff - bls_ff;
            rsp_left_sqsum_out <= blq_ff;
            rsp_right_sqsum_out <= (nq_ff >= blq_ff) ? nq_ff - blq_ff : '0;
         end else begin
            rsp_best_feature_out <= '0;
            rsp_threshold <= '0;
            rsp_left_count_out <= '0;
            rsp_right_count_out <= '0;
            rsp_left_sum_out <= '0;
            rsp_right_sum_out <= '0;
            rsp_left_sqsum_out <= '0;
            rsp_right_sqsum_out <= '0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[hdl/rtsf_controller.sv]
module rtsf_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [1:0]           req_opcode,
   input  rtsf_pkg::sts_type    sts,
   output logic                 busy,
   output logic                 accept,
   output rtsf_pkg::ctl_type    ctl
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_READ,
      S_CHECK,
      S_MUL_L,
      S_DIV_L,
      S_WAIT_L,
      S_MUL_R,
      S_DIV_R,
      S_WAIT_R,
      S_KEEP,
      S_JOIN
   } state_type;

   state_type state_ff;
   logic      report_ff;
   logic      busy_ff;

   assign accept = start && !busy_ff;
   assign busy = busy_ff;

   always_comb begin
      ctl = '0;
      case (state_ff)
         S_READ: ctl.load = 1'b1;
         S_CHECK: begin
            ctl.sample = !report_ff;
            ctl.report = report_ff;
         end
         S_MUL_L: ctl.mul_l = 1'b1;
         S_DIV_L: ctl.div_start = 1'b1;
         S_WAIT_L: begin
            ctl.take_a = sts.div_done;
         end
         S_MUL_R: ctl.mul_r = 1'b1;
         S_DIV_R: begin
            ctl.div_start = 1'b1;
            ctl.div_sel_r = 1'b1;
         end
         S_WAIT_R: ctl.div_sel_r = 1'b1;
         S_KEEP: ctl.take_b = 1'b1;
         S_JOIN: ctl.finish = 1'b1;
         default: ctl = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff <= 1'b0;
         report_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (accept && (rtsf_pkg::op_type'(req_opcode) == rtsf_pkg::OP_SAMPLE
                     || rtsf_pkg::op_type'(req_opcode) == rtsf_pkg::OP_REPORT)) begin
                  state_ff <= S_READ;
                  busy_ff <= 1'b1;
                  report_ff <= rtsf_pkg::op_type'(req_opcode) == rtsf_pkg::OP_REPORT;
               end
            end
            S_READ: state_ff <= S_CHECK;
            S_CHECK: begin
               if (report_ff) begin
                  state_ff <= S_IDLE;
                  busy_ff <= 1'b0;
               end else if (sts.skip) begin
                  state_ff <= S_IDLE;
                  busy_ff <= 1'b0;
               end else if (sts.can_score) begin
                  state_ff <= S_MUL_L;
               end else begin
                  state_ff <= S_JOIN;
               end
            end
            S_MUL_L: state_ff <= S_DIV_L;
            S_DIV_L: state_ff <= S_WAIT_L;
            S_WAIT_L: if (sts.div_done) begin
               state_ff <= S_MUL_R;
            end
            S_MUL_R: state_ff <= S_DIV_R;
            S_DIV_R: state_ff <= S_WAIT_R;
            S_WAIT_R: if (sts.div_done) begin
               state_ff <= S_KEEP;
            end
            S_KEEP: state_ff <= S_JOIN;
            S_JOIN: begin
               state_ff <= S_IDLE;
               busy_ff <= 1'b0;
            end
            default: begin
               state_ff <= S_IDLE;
               busy_ff <= 1'b0;
            end
         endcase
      end
   end

endmodule
